// ----- src/status_edge_alarm_beeper_defines.svh -----
// assertion macros for the status edge alarm beeper checker
// no dependencies
`ifndef STATUS_EDGE_ALARM_BEEPER_DEFINES_SVH
`define STATUS_EDGE_ALARM_BEEPER_DEFINES_SVH
// implication checked on every clock, off during reset
`define SEAB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, off during reset
`define SEAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/seab_pkg.sv -----
// package for the status edge alarm beeper: constants, codes, types
// no dependencies
`default_nettype none
package seab_pkg;
  localparam int unsigned EVAL_PERIOD_MS_DEF = 200;
  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int IN_BITS = 112;
  localparam int OUT_BITS = 200;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0, OP_CLICK = 2'd1, OP_TEST = 2'd2, OP_CLEAR = 2'd3
  } op_t;
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0, PH_ON = 2'd1, PH_OFF = 2'd2
  } phase_t;
  typedef enum logic [1:0] {
    VD_PASS = 2'd0, VD_BELOW = 2'd1, VD_ABOVE = 2'd2, VD_NONE = 2'd3
  } verdict_t;
  typedef enum logic [2:0] {
    REG_BAT_EN = 3'd0, REG_BAT_LOW = 3'd1, REG_OVEN_EN = 3'd2, REG_OVEN_LOW = 3'd3,
    REG_OVEN_HIGH = 3'd4, REG_STAB_EN = 3'd5, REG_STAB_MAX = 3'd6, REG_LIMIT_EN = 3'd7
  } reg_t;

  // pattern shapes
  typedef struct packed {
    logic [2:0] pulses;
    logic [7:0] on_ms;
    logic [7:0] off_ms;
  } pat_t;
  localparam pat_t PAT_ALARM = '{3'd3, 8'd200, 8'd120};
  localparam pat_t PAT_OK = '{3'd1, 8'd150, 8'd0};
  localparam pat_t PAT_LINK = '{3'd3, 8'd80, 8'd80};
  localparam pat_t PAT_GPS = '{3'd2, 8'd120, 8'd120};
  localparam pat_t PAT_LIMIT = '{3'd4, 8'd70, 8'd70};
  localparam pat_t PAT_CLICK = '{3'd1, 8'd12, 8'd0};
  localparam pat_t PAT_TEST = '{3'd2, 8'd100, 8'd100};
endpackage
`default_nettype wire

// ----- src/status_edge_alarm_beeper.sv -----
// status edge alarm beeper top level: beat registers, pattern player, monitors
// depends on seab_pkg
`default_nettype none
// One beat in, one beat out. Each accepted input beat is worked in one pass
// of combinational logic from the state registers and lands in an output
// register the next cycle; a new beat is taken every cycle as long as the
// output register is empty or being drained (in steady state 1 beat per
// cycle sustained). The beat runs the operation code first (click request,
// test pattern, counter clear), then services the beep pattern timed against
// now_ms, then, once EVAL_PERIOD_MS has passed since the last evaluation,
// updates the battery, oven and stability hysteresis monitors and the link,
// gps lock and limit verdict edge detectors; the last pattern start wins.
// Mute stops any pattern but monitors and counters keep running. Counters
// wrap at COUNTER_WIDTH bits and are zero-extended to 32 on the output.
// Configuration writes are meant to happen only while no beat is in flight.
module status_edge_alarm_beeper #(
  parameter int unsigned EVAL_PERIOD_MS = seab_pkg::EVAL_PERIOD_MS_DEF,
  parameter int unsigned COUNTER_WIDTH = seab_pkg::COUNTER_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation[1:0], now_ms[33:2], muted[34], link_stale[35], gps_valid[36],
  // gps_fix_mode[38:37], meas_verdict[40:39], battery_valid[41],
  // battery_mv[57:42], oven_valid[58], oven_temp_centi[74:59],
  // stability_value[106:75], zero fill
  input  logic [seab_pkg::IN_BITS-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // beeper_on[0], battery_bad[1], oven_bad[2], stability_bad[3],
  // link_lost_count[35:4], gps_lost_count[67:36], limit_fail_count[99:68],
  // battery_alarm_count[131:100], oven_alarm_count[163:132],
  // stability_alarm_count[195:164], zero fill
  output logic [seab_pkg::OUT_BITS-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import seab_pkg::*;

  // floor(x/10) for any 32-bit x is (x * RECIP10) >> 35
  localparam logic [63:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;

  // configuration registers
  logic bat_en, oven_en, stab_en, alarm_lim_en;
  logic [15:0] bat_low;
  logic signed [15:0] oven_low, oven_high;
  logic [31:0] stab_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      bat_en <= 1'b1; bat_low <= 16'd2800; oven_en <= 1'b1;
      oven_low <= 16'sd4500; oven_high <= 16'sd5500;
      stab_en <= 1'b0; stab_max <= 32'd1000; alarm_lim_en <= 1'b0;
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_BAT_EN: bat_en <= cfg_data[0];
        REG_BAT_LOW: bat_low <= cfg_data[15:0];
        REG_OVEN_EN: oven_en <= cfg_data[0];
        REG_OVEN_LOW: oven_low <= cfg_data[15:0];
        REG_OVEN_HIGH: oven_high <= cfg_data[15:0];
        REG_STAB_EN: stab_en <= cfg_data[0];
        REG_STAB_MAX: stab_max <= cfg_data;
        REG_LIMIT_EN: alarm_lim_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input field decode
  logic [1:0] op;
  logic [31:0] now;
  logic muted, link_bad, lock, bat_ok, oven_ok;
  logic [1:0] verdict;
  logic [15:0] bat;
  logic signed [15:0] oven;
  logic [31:0] stab;
  assign op = s_axis_tdata[1:0];
  assign now = s_axis_tdata[33:2];
  assign muted = s_axis_tdata[34];
  assign link_bad = s_axis_tdata[35];
  assign lock = s_axis_tdata[36] | s_axis_tdata[38];
  assign verdict = s_axis_tdata[40:39];
  assign bat_ok = s_axis_tdata[41];
  assign bat = s_axis_tdata[57:42];
  assign oven_ok = s_axis_tdata[58];
  assign oven = s_axis_tdata[74:59];
  assign stab = s_axis_tdata[106:75];

  // state
  phase_t phase, phase_next;
  logic [2:0] pulses, pulses_next;
  logic [7:0] on_ms, on_ms_next, off_ms, off_ms_next;
  logic [31:0] deadline, deadline_next;
  logic level, level_next, click, click_next;
  logic [31:0] eval_ms, eval_ms_next;
  logic [5:0] eflags, eflags_next, mflags, mflags_next;
  logic [COUNTER_WIDTH-1:0] cnt [6];
  logic [COUNTER_WIDTH-1:0] cnt_next [6];

  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // stability hysteresis release point: max - floor(max/10)
  logic [63:0] stab_tenth_prod;
  logic [31:0] stab_rel;
  assign stab_tenth_prod = 64'(stab_max) * RECIP10;
  assign stab_rel = stab_max - {3'b000, stab_tenth_prod[63:35]};

  always_comb begin
    logic [31:0] diff;
    logic active, fail, pass, prev, ever, bad, start;
    logic [2:0] bumps;
    logic signed [17:0] olo, ohi, ov;
    pat_t pat;
    phase_next = phase; pulses_next = pulses; on_ms_next = on_ms; off_ms_next = off_ms;
    deadline_next = deadline; level_next = level; click_next = click;
    eval_ms_next = eval_ms; eflags_next = eflags; mflags_next = mflags;
    for (int i = 0; i < 6; i++) cnt_next[i] = cnt[i];
    start = 1'b0; pat = PAT_OK; bumps = '0;
    active = alarm_lim_en;
    fail = (verdict == VD_BELOW) || (verdict == VD_ABOVE);
    pass = (verdict == VD_PASS);
    olo = 18'(oven_low); ohi = 18'(oven_high); ov = 18'(oven);
    prev = 1'b0; ever = 1'b0; bad = 1'b0;

    case (op_t'(op))
      OP_CLICK: click_next = 1'b1;
      OP_TEST: begin
        pulses_next = PAT_TEST.pulses; on_ms_next = PAT_TEST.on_ms;
        off_ms_next = PAT_TEST.off_ms; phase_next = PH_ON;
        deadline_next = now + 32'(PAT_TEST.on_ms); level_next = 1'b1;
      end
      OP_CLEAR: for (int i = 0; i < 6; i++) cnt_next[i] = '0;
      default: ;
    endcase

    diff = now - deadline_next;
    if (muted) begin
      phase_next = PH_IDLE; pulses_next = '0; level_next = 1'b0;
    end else if (phase_next != PH_IDLE && !diff[31]) begin
      if (phase_next == PH_ON) begin
        level_next = 1'b0;
        pulses_next = pulses_next - 3'd1;
        if (pulses_next == 3'd0) phase_next = PH_IDLE;
        else begin
          phase_next = PH_OFF; deadline_next = now + 32'(off_ms_next);
        end
      end else begin
        level_next = 1'b1; phase_next = PH_ON;
        deadline_next = now + 32'(on_ms_next);
      end
    end
    if (click_next) begin
      click_next = 1'b0;
      if (!muted && phase_next == PH_IDLE) begin
        start = 1'b1; pat = PAT_CLICK;
      end
    end

    if ((now - eval_ms) >= 32'(EVAL_PERIOD_MS)) begin
      eval_ms_next = now;
      // battery monitor
      if (bat_en) begin
        if (bat_ok) begin
          bad = mflags[0] ? !({1'b0, bat} > {1'b0, bat_low} + 17'd30) : (bat < bat_low);
          if (!bad) begin
            if (mflags[0] && mflags[3] && !muted) begin start = 1'b1; pat = PAT_OK; end
            mflags_next[3] = 1'b1;
          end else if (!mflags[0] && mflags[3]) begin
            if (!muted) begin start = 1'b1; pat = PAT_ALARM; end
            bumps[0] = 1'b1;
          end
          mflags_next[0] = bad;
        end
      end else begin
        mflags_next[0] = 1'b0; mflags_next[3] = 1'b0;
      end
      // oven monitor
      if (oven_en) begin
        if (oven_ok) begin
          bad = mflags[1] ? !(ov > olo + 18'sd50 && ov < ohi - 18'sd50)
                          : (ov < olo || ov > ohi);
          if (!bad) begin
            if (mflags[1] && mflags[4] && !muted) begin start = 1'b1; pat = PAT_OK; end
            mflags_next[4] = 1'b1;
          end else if (!mflags[1] && mflags[4]) begin
            if (!muted) begin start = 1'b1; pat = PAT_ALARM; end
            bumps[1] = 1'b1;
          end
          mflags_next[1] = bad;
        end
      end else begin
        mflags_next[1] = 1'b0; mflags_next[4] = 1'b0;
      end
      // stability monitor
      if (stab_en) begin
        if (stab != 32'd0) begin
          bad = mflags[2] ? !(stab < stab_rel) : (stab > stab_max);
          if (!bad) begin
            if (mflags[2] && mflags[5] && !muted) begin start = 1'b1; pat = PAT_OK; end
            mflags_next[5] = 1'b1;
          end else if (!mflags[2] && mflags[5]) begin
            if (!muted) begin start = 1'b1; pat = PAT_ALARM; end
            bumps[2] = 1'b1;
          end
          mflags_next[2] = bad;
        end
      end else begin
        mflags_next[2] = 1'b0; mflags_next[5] = 1'b0;
      end
      for (int i = 0; i < 3; i++)
        if (bumps[i]) cnt_next[3+i] = cnt_next[3+i] + 1'b1;

      // edge detectors: bit0 link prev, 1 link ever, 2 gps prev, 3 gps ever,
      // 4 limit prev, 5 limit ever
      if (muted) begin
        if (!link_bad) eflags_next[1] = 1'b1;
        eflags_next[0] = link_bad;
        if (lock) eflags_next[3] = 1'b1;
        eflags_next[2] = lock;
        if (!active) eflags_next[5:4] = 2'b00;
        else begin
          if (pass) eflags_next[5] = 1'b1;
          eflags_next[4] = fail;
        end
      end else begin
        prev = eflags[0]; ever = eflags[1];
        if (!link_bad && prev) begin
          if (ever) begin start = 1'b1; pat = PAT_OK; end
          eflags_next[1] = 1'b1;
        end else if (link_bad && !prev && ever) begin
          start = 1'b1; pat = PAT_LINK;
          cnt_next[0] = cnt_next[0] + 1'b1;
        end
        eflags_next[0] = link_bad;
        prev = eflags[2]; ever = eflags[3];
        if (lock && !prev) begin
          if (ever) begin start = 1'b1; pat = PAT_OK; end
          eflags_next[3] = 1'b1;
        end else if (!lock && prev && ever) begin
          start = 1'b1; pat = PAT_GPS;
          cnt_next[1] = cnt_next[1] + 1'b1;
        end
        eflags_next[2] = lock;
        if (!active) eflags_next[5:4] = 2'b00;
        else begin
          prev = eflags[4]; ever = eflags[5];
          if (fail && !prev && ever) begin
            start = 1'b1; pat = PAT_LIMIT;
            cnt_next[2] = cnt_next[2] + 1'b1;
          end else if (!fail && prev) begin
            start = 1'b1; pat = PAT_OK;
          end
          if (pass) eflags_next[5] = 1'b1;
          eflags_next[4] = fail;
        end
      end
    end

    // the last pattern start of the beat wins
    if (start) begin
      pulses_next = pat.pulses; on_ms_next = pat.on_ms; off_ms_next = pat.off_ms;
      phase_next = PH_ON; deadline_next = now + 32'(pat.on_ms); level_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; pulses <= '0; on_ms <= '0; off_ms <= '0; deadline <= '0;
      level <= 1'b0; click <= 1'b0; eval_ms <= '0;
      eflags <= 6'b000001; mflags <= '0;
      for (int i = 0; i < 6; i++) cnt[i] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next; pulses <= pulses_next; on_ms <= on_ms_next;
        off_ms <= off_ms_next; deadline <= deadline_next; level <= level_next;
        click <= click_next; eval_ms <= eval_ms_next;
        eflags <= eflags_next; mflags <= mflags_next;
        for (int i = 0; i < 6; i++) cnt[i] <= cnt_next[i];
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // output payload, packed as listed at the port
  logic [OUT_BITS-1:0] status_word;
  always_comb begin
    status_word = '0;
    status_word[0] = level_next;
    status_word[3:1] = mflags_next[2:0];
    for (int i = 0; i < 6; i++)
      status_word[4 + 32*i +: 32] = 32'(cnt_next[i]);
  end

  always_ff @(posedge clk) begin
    if (accept) m_axis_tdata <= status_word;
  end
endmodule
`default_nettype wire

// ----- src/seab_checker.sv -----
// port-level checker for the status edge alarm beeper, bound to the top level
// depends on seab_pkg and status_edge_alarm_beeper_defines.svh
`default_nettype none
`include "status_edge_alarm_beeper_defines.svh"
module seab_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic [seab_pkg::IN_BITS-1:0] s_axis_tdata,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [seab_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import seab_pkg::*;
  // an accepted beat always yields a result the next cycle
  `SEAB_ASSERT_NEXT(a_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "beat lost")
  // input side never blocks while the output is empty
  `SEAB_ASSERT(a_ready, !m_axis_tvalid, s_axis_tready, "ready low with empty output")
  // a muted beat always leaves the beeper off
  `SEAB_ASSERT_NEXT(a_mute, s_axis_tvalid && s_axis_tready && s_axis_tdata[34],
    !m_axis_tdata[0], "beeper on while muted")
  // a stalled result holds
  `SEAB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
bind status_edge_alarm_beeper seab_checker u_seab_checker (.*);
`default_nettype wire
